/* rtl/mtep_pkg.sv */
// Shared types and codes for the MIDI track event parser.
package mtep_pkg;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        track_start;
        logic [15:0] track_number;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] track_id;
        logic [31:0] tick_time;
        logic [6:0]  note_key;
        logic [6:0]  note_velocity;
        logic [23:0] slowest_tempo;
    } t_out_item;

    // One item presented to the parse core, with its go signal.
    typedef struct packed {
        logic     fire;
        t_in_item item;
    } t_step;

    typedef enum logic [3:0] {
        PH_DELTA  = 4'd0,
        PH_STATUS = 4'd1,
        PH_DATA1  = 4'd2,
        PH_DATA2  = 4'd3,
        PH_MTYPE  = 4'd4,
        PH_MLEN   = 4'd5,
        PH_SKIP   = 4'd6,
        PH_FIXLEN = 4'd7,
        PH_TEMPO  = 4'd8,
        PH_ENDED  = 4'd9
    } t_phase;

    localparam logic [1:0] KIND_NOTE  = 2'd0;
    localparam logic [1:0] KIND_TEMPO = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [7:0] STATUS_META  = 8'hff;
    localparam logic [7:0] META_TEXT_HI = 8'h07;
    localparam logic [7:0] META_SEQ_SP  = 8'h7f;
    localparam logic [7:0] META_CH_PFX  = 8'h20;
    localparam logic [7:0] META_PORT    = 8'h21;
    localparam logic [7:0] META_EOT     = 8'h2f;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] META_TIMESIG = 8'h58;
    localparam logic [7:0] META_KEYSIG  = 8'h59;

    localparam logic [3:0] MSG_NOTE_OFF  = 4'h8;
    localparam logic [3:0] MSG_NOTE_ON   = 4'h9;
    localparam logic [3:0] MSG_PROGRAM   = 4'hc;
    localparam logic [3:0] MSG_CH_PRESS  = 4'hd;
    localparam logic [3:0] MSG_SYSTEM    = 4'hf;

    localparam logic [23:0] TEMPO_NONE = 24'hffffff;

endpackage

/* rtl/mtep_in_stage.sv */
// Input register of the MIDI track event parser.
module mtep_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  mtep_pkg::t_in_item i_item,
    input  logic              i_adv,
    output mtep_pkg::t_step   o_step
);
    import mtep_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     load;

    assign load    = !r_valid || i_adv;
    assign o_stall = !load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_step.fire = r_valid && i_adv;
    assign o_step.item = r_item;

endmodule

/* rtl/mtep_core.sv */
// Parse state and per-byte decode of the MIDI track event parser.
module mtep_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mtep_pkg::t_step    i_step,
    output logic               o_emit,
    output mtep_pkg::t_out_item o_result
);
    import mtep_pkg::*;

    t_phase      r_phase,     n_phase,     s_phase;
    logic [27:0] r_len_accum, n_len_accum, s_len_accum;
    logic [2:0]  r_len_bytes, n_len_bytes, s_len_bytes;
    logic [31:0] r_time,      n_time,      s_time;
    logic [7:0]  r_run,       n_run,       s_run;
    logic [6:0]  r_key,       n_key,       s_key;
    logic [27:0] r_skip,      n_skip,      s_skip;
    logic [7:0]  r_meta,      n_meta,      s_meta;
    logic [23:0] r_tempo,     n_tempo,     s_tempo;
    logic [23:0] r_min_tempo, n_min_tempo;
    logic        r_halted,    n_halted,    s_halted;

    logic [7:0]  b;
    logic        start;
    logic [27:0] v_accum;
    logic [2:0]  v_bytes;
    logic        v_done;
    logic        v_err;
    logic [27:0] skip_dec;
    logic [23:0] tempo_shift;
    logic [3:0]  msg;
    logic        emit;
    logic [1:0]  kind;
    logic [6:0]  out_key;
    logic [6:0]  out_vel;

    assign b     = i_step.item.data_byte;
    assign start = i_step.item.track_start;

    always_comb begin
        // A track start clears the parse before this byte is decoded.
        s_phase     = start ? PH_DELTA : r_phase;
        s_len_accum = start ? '0 : r_len_accum;
        s_len_bytes = start ? '0 : r_len_bytes;
        s_time      = start ? '0 : r_time;
        s_run       = start ? '0 : r_run;
        s_key       = start ? '0 : r_key;
        s_skip      = start ? '0 : r_skip;
        s_meta      = start ? '0 : r_meta;
        s_tempo     = start ? '0 : r_tempo;
        s_halted    = start ? 1'b0 : r_halted;

        v_accum     = {s_len_accum[20:0], b[6:0]};
        v_bytes     = 3'(s_len_bytes + 3'd1);
        v_done      = !b[7];
        v_err       = b[7] && (v_bytes >= 3'd4);
        skip_dec    = 28'(s_skip - 28'd1);
        tempo_shift = {s_tempo[15:0], b};
        msg         = s_run[7:4];

        n_phase     = s_phase;
        n_len_accum = s_len_accum;
        n_len_bytes = s_len_bytes;
        n_time      = s_time;
        n_run       = s_run;
        n_key       = s_key;
        n_skip      = s_skip;
        n_meta      = s_meta;
        n_tempo     = s_tempo;
        n_min_tempo = r_min_tempo;
        n_halted    = s_halted;
        emit        = 1'b0;
        kind        = KIND_ERROR;
        out_key     = '0;
        out_vel     = '0;

        if (!s_halted && s_phase != PH_ENDED) begin
            case (s_phase)
                PH_DELTA: begin
                    n_len_accum = v_accum;
                    n_len_bytes = v_bytes;
                    if (v_err) begin
                        emit     = 1'b1;
                        n_halted = 1'b1;
                    end else if (v_done) begin
                        n_time      = s_time + {4'd0, v_accum};
                        n_len_accum = '0;
                        n_len_bytes = '0;
                        n_phase     = PH_STATUS;
                    end
                end
                PH_STATUS, PH_DATA1: begin
                    if (s_phase == PH_STATUS && b == STATUS_META) begin
                        n_run   = '0;
                        n_phase = PH_MTYPE;
                    end else if (s_phase == PH_STATUS && b[7]) begin
                        if (b[7:4] == MSG_SYSTEM) begin
                            emit     = 1'b1;
                            n_halted = 1'b1;
                        end else begin
                            n_run   = b;
                            n_phase = PH_DATA1;
                        end
                    end else if (b[7] || (s_phase == PH_STATUS && !s_run[7])) begin
                        // Bad data byte, or data with no running status.
                        emit     = 1'b1;
                        n_halted = 1'b1;
                    end else if (msg == MSG_PROGRAM || msg == MSG_CH_PRESS) begin
                        n_phase = PH_DELTA;
                    end else begin
                        n_key   = b[6:0];
                        n_phase = PH_DATA2;
                    end
                end
                PH_DATA2: begin
                    if (b[7]) begin
                        emit     = 1'b1;
                        n_halted = 1'b1;
                    end else begin
                        n_phase = PH_DELTA;
                        if (msg == MSG_NOTE_OFF || msg == MSG_NOTE_ON) begin
                            emit    = 1'b1;
                            kind    = KIND_NOTE;
                            out_key = s_key;
                            out_vel = b[6:0];
                        end
                    end
                end
                PH_MTYPE: begin
                    n_meta = b;
                    if (b <= META_TEXT_HI || b == META_SEQ_SP) begin
                        n_len_accum = '0;
                        n_len_bytes = '0;
                        n_phase     = PH_MLEN;
                    end else if (b == META_CH_PFX || b == META_PORT || b == META_EOT
                            || b == META_TEMPO || b == META_TIMESIG || b == META_KEYSIG) begin
                        n_phase = PH_FIXLEN;
                    end else begin
                        emit     = 1'b1;
                        n_halted = 1'b1;
                    end
                end
                PH_MLEN: begin
                    n_len_accum = v_accum;
                    n_len_bytes = v_bytes;
                    if (v_err) begin
                        emit     = 1'b1;
                        n_halted = 1'b1;
                    end else if (v_done) begin
                        n_len_accum = '0;
                        n_len_bytes = '0;
                        n_skip      = v_accum;
                        n_phase     = (v_accum == '0) ? PH_DELTA : PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == '0) begin
                        n_phase = PH_DELTA;
                    end
                end
                PH_FIXLEN: begin
                    if (s_meta == META_CH_PFX || s_meta == META_PORT) begin
                        n_skip  = 28'd1;
                        n_phase = PH_SKIP;
                    end else if (s_meta == META_EOT && b == 8'd0) begin
                        n_phase = PH_ENDED;
                        emit    = 1'b1;
                        kind    = KIND_END;
                    end else if (s_meta == META_TEMPO && b == 8'd3) begin
                        n_tempo     = '0;
                        n_len_bytes = '0;
                        n_phase     = PH_TEMPO;
                    end else if (s_meta == META_TIMESIG && b == 8'd4) begin
                        n_skip  = 28'd4;
                        n_phase = PH_SKIP;
                    end else if (s_meta == META_KEYSIG && b == 8'd2) begin
                        n_skip  = 28'd2;
                        n_phase = PH_SKIP;
                    end else begin
                        emit     = 1'b1;
                        n_halted = 1'b1;
                    end
                end
                PH_TEMPO: begin
                    n_tempo     = tempo_shift;
                    n_len_bytes = v_bytes;
                    if (v_bytes >= 3'd3) begin
                        n_len_bytes = '0;
                        if (tempo_shift < r_min_tempo) begin
                            n_min_tempo = tempo_shift;
                        end
                        n_phase = PH_DELTA;
                        emit    = 1'b1;
                        kind    = KIND_TEMPO;
                    end
                end
                default: begin
                    n_phase = PH_ENDED;
                end
            endcase
        end

        o_emit                 = emit;
        o_result.kind          = kind;
        o_result.track_id      = i_step.item.track_number;
        o_result.tick_time     = n_time;
        o_result.note_key      = out_key;
        o_result.note_velocity = out_vel;
        o_result.slowest_tempo = n_min_tempo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DELTA;
            r_len_accum <= '0;
            r_len_bytes <= '0;
            r_time      <= '0;
            r_run       <= '0;
            r_key       <= '0;
            r_skip      <= '0;
            r_meta      <= '0;
            r_tempo     <= '0;
            r_min_tempo <= TEMPO_NONE;
            r_halted    <= 1'b0;
        end else if (i_step.fire) begin
            r_phase     <= n_phase;
            r_len_accum <= n_len_accum;
            r_len_bytes <= n_len_bytes;
            r_time      <= n_time;
            r_run       <= n_run;
            r_key       <= n_key;
            r_skip      <= n_skip;
            r_meta      <= n_meta;
            r_tempo     <= n_tempo;
            r_min_tempo <= n_min_tempo;
            r_halted    <= n_halted;
        end
    end

    // An error result always leaves the parser halted.
    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step.fire && o_emit && o_result.kind == KIND_ERROR) |=> r_halted)
        else $error("error result without halt");

    // Halted parser stays silent until a track start.
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step.fire && r_halted && !i_step.item.track_start) |-> !o_emit)
        else $error("result while halted");

    // Slowest tempo never increases except at reset.
    a_tempo_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_min_tempo <= $past(r_min_tempo)))
        else $error("slowest tempo increased");

endmodule

/* rtl/mtep_out_stage.sv */
// Result register of the MIDI track event parser.
module mtep_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic                i_emit,
    input  mtep_pkg::t_out_item i_result,
    output logic                o_adv,
    output logic                o_valid,
    input  logic                i_stall,
    output mtep_pkg::t_out_item o_item
);
    import mtep_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    // Free when empty or when the held result leaves this cycle.
    assign o_adv = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_fire && i_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_fire && i_emit) begin
            r_item <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/midi_track_event_parser.sv */
// Top level of the MIDI track event parser: input register, parse core, result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one track byte per
//   item with its track_start flag and track number. Output channel (o_out_valid /
//   i_out_stall / o_out_item) carries at most one result per byte: a note, a tempo
//   update, end of track or a parse error. An item moves when valid is high and stall
//   is low at a rising edge.
//   Throughput is one byte per cycle while the receiver does not stall; the parse core
//   decodes a byte combinationally from the input register into the result register.
//   An accepted byte waits in the input register until the result register is free,
//   and its result is then loaded into the result register, which drives the output.
//   When the receiver stalls while a result is held, the core stops and the input
//   register holds one more byte; o_in_stall rises only then.
//   Reset (i_rst_n low, synchronous) empties both registers, returns the parse to
//   waiting for a delta time and sets the slowest tempo to all ones. A track start
//   clears time, running status and parse but keeps the slowest tempo.
module midi_track_event_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mtep_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mtep_pkg::t_out_item o_out_item
);
    import mtep_pkg::*;

    t_step     step;
    logic      adv;
    logic      emit;
    t_out_item result;

    // Hold the next byte while the core waits on the result register.
    mtep_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .i_adv   (adv),
        .o_step  (step)
    );

    // Decode one byte per fire and advance the track state.
    mtep_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .o_emit   (emit),
        .o_result (result)
    );

    // Capture the result; free means the core may advance.
    mtep_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (step.fire),
        .i_emit   (emit),
        .i_result (result),
        .o_adv    (adv),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_item   (o_out_item)
    );

endmodule
